// ===== src/smallest_covering_range_window_core_macros.svh =====
// Assertion macros shared by the smallest covering range window RTL.
`ifndef SMALLEST_COVERING_RANGE_WINDOW_CORE_MACROS_SVH
`define SMALLEST_COVERING_RANGE_WINDOW_CORE_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define SCRW_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a consequent holds in the same cycle as its antecedent.
`define SCRW_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check that a consequent holds in the cycle after its antecedent.
`define SCRW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/scrw_pkg.sv =====
// Constants and types for the smallest covering range window block.
package scrw_pkg;

  localparam int MAX_LISTS    = 16;
  localparam int WINDOW_DEPTH = 1024;

  localparam int VALUE_W = 32;
  localparam int LIST_W  = 4;
  localparam int TOTAL_W = 5;
  localparam int PTR_W   = $clog2(WINDOW_DEPTH);
  localparam int FILL_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int COUNT_W = FILL_W;
  localparam int SPAN_W  = VALUE_W + 2;

  // Best length before any covering window: 33 ones, positive in SPAN_W bits.
  localparam logic signed [SPAN_W-1:0] LEN_INIT = {1'b0, {(SPAN_W-1){1'b1}}};

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [LIST_W-1:0]  list_id;
  } ring_entry_t;

  typedef struct packed {
    logic               clear;
    logic               rd_en;
    logic [LIST_W-1:0]  rd_addr;
    logic               wr_en;
    logic [LIST_W-1:0]  wr_addr;
    logic [COUNT_W-1:0] wr_data;
  } cnt_req_t;

endpackage

// ===== src/scrw_cfg_if.sv =====
// Configuration write channel carrying the list total.
interface scrw_cfg_if import scrw_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [TOTAL_W-1:0] data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ===== src/scrw_elem_if.sv =====
// Input channel carrying one element item.
interface scrw_elem_if import scrw_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;
  logic [LIST_W-1:0]         list_id;
  logic                      first;
  logic                      last;

  modport source(output valid, output value, output list_id, output first, output last,
                 input ready);
  modport sink(input valid, input value, input list_id, input first, input last,
               output ready);
endinterface

// ===== src/scrw_out_if.sv =====
// Result channel carrying the best range item.
interface scrw_out_if import scrw_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] best_low;
  logic signed [VALUE_W-1:0] best_high;
  logic                      found;
  logic                      overflowed;
  logic                      done_res;

  modport source(output valid, output best_low, output best_high, output found,
                 output overflowed, output done_res, input ready);
  modport sink(input valid, input best_low, input best_high, input found,
               input overflowed, input done_res, output ready);
endinterface

// ===== src/scrw_counts.sv =====
// Per-list count store: synchronous memory with valid bits that clear every entry at once.
module scrw_counts import scrw_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  cnt_req_t           req,
  output logic [COUNT_W-1:0] rd_data
);

  logic [COUNT_W-1:0]   mem [MAX_LISTS];
  logic [MAX_LISTS-1:0] valid;
  logic [COUNT_W-1:0]   rd_raw;
  logic                 rd_valid;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_raw <= mem[req.rd_addr];
    end
  end

  // An entry never written since the last clear reads as zero.
  always_ff @(posedge clk) begin
    if (rst || req.clear) begin
      valid <= '0;
    end else if (req.wr_en) begin
      valid[req.wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else if (req.rd_en) begin
      rd_valid <= valid[req.rd_addr];
    end
  end

  assign rd_data = rd_valid ? rd_raw : '0;

endmodule

// ===== src/smallest_covering_range_window_core.sv =====
// Smallest covering range window: top level with ring buffer and item sequencer.
//
// Takes elements (value, list id) in nondecreasing value order and returns one
// result item per element: the smallest range so far that covers every list
// 0 .. list_total-1 (first such range wins ties), a found flag, a sticky ring
// overflow flag and an echo of last. The window lives in a 1024-entry ring
// memory, the per-list counts in a 16-entry count memory; both are read
// through a registered read port, and the sequencer walks each item through
// read, modify and write-back steps one at a time, so accesses to one entry
// never overlap and need no forwarding. An ignored item is checked and then
// reported; any other item is appended and its list count incremented, and
// if all lists are then covered, front entries whose list still occurs later
// are dropped before the span is compared. When the ring is full, the oldest
// entry is evicted first. Each dropped or evicted entry takes a serial
// count-memory round trip (ring read, count read, count write). A new item is
// taken as soon as the sequencer is back at rest, while the previous result
// may still sit in the output register. First clears the problem state in
// the cycle of acceptance (the count memory through its valid bits), so no
// clearing pass is needed after reset. list_total of 0 acts as 1, above 16 as
// 16; items whose list id is not below it leave the window alone but report.
`include "smallest_covering_range_window_core_macros.svh"

module smallest_covering_range_window_core import scrw_pkg::*; (
  input logic     clk,
  input logic     rst,
  scrw_cfg_if.sink     cfg,
  scrw_elem_if.sink    elem,
  scrw_out_if.source   result
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_CHECK  = 4'd1;
  localparam logic [3:0] ST_HEAD   = 4'd2;
  localparam logic [3:0] ST_LIST   = 4'd3;
  localparam logic [3:0] ST_COUNT  = 4'd4;
  localparam logic [3:0] ST_APPEND = 4'd5;
  localparam logic [3:0] ST_INC    = 4'd6;
  localparam logic [3:0] ST_COVER  = 4'd7;
  localparam logic [3:0] ST_SHRINK = 4'd8;
  localparam logic [3:0] ST_FRONT  = 4'd9;
  localparam logic [3:0] ST_SPAN   = 4'd10;
  localparam logic [3:0] ST_EMIT   = 4'd11;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
    return (ptr == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : ptr + 1'b1;
  endfunction

  // Sequencer and item registers
  logic [3:0]                state;
  logic                      drop_mode;
  logic [TOTAL_W-1:0]        list_total;
  logic signed [VALUE_W-1:0] cur_value;
  logic [LIST_W-1:0]         cur_list;
  logic                      cur_last;

  // Window bookkeeping
  logic [PTR_W-1:0]   head;
  logic [PTR_W-1:0]   tail;
  logic [FILL_W-1:0]  fill;
  logic [TOTAL_W-1:0] covered;

  // Best range so far
  logic signed [SPAN_W-1:0]  best_len;
  logic signed [VALUE_W-1:0] best_low;
  logic signed [VALUE_W-1:0] best_high;
  logic                      found_flag;
  logic                      overflow_flag;

  // Output register
  logic out_valid;

  // Ring memory
  ring_entry_t ring [WINDOW_DEPTH];
  ring_entry_t ring_rd;
  logic        ring_re;
  logic        ring_we;

  // Count memory
  cnt_req_t           cnt_req;
  logic [COUNT_W-1:0] cnt_rd;

  logic [TOTAL_W-1:0]       total_eff;
  logic                     list_ok;
  logic                     accept;
  logic                     emit_load;
  logic signed [SPAN_W-1:0] span;

  // Clamp the list total into 1 .. MAX_LISTS.
  always_comb begin
    if (list_total == '0) begin
      total_eff = TOTAL_W'(1);
    end else if (list_total > TOTAL_W'(MAX_LISTS)) begin
      total_eff = TOTAL_W'(MAX_LISTS);
    end else begin
      total_eff = list_total;
    end
  end

  assign list_ok   = {1'b0, cur_list} < total_eff;
  assign accept    = elem.valid && elem.ready;
  assign emit_load = (state == ST_EMIT) && (!out_valid || result.ready);

  assign elem.ready = (state == ST_IDLE);
  assign cfg.ready  = 1'b1;

  // Span of the window: back value minus front value plus one, exact and signed.
  assign span = SPAN_W'(cur_value) - SPAN_W'($signed(ring_rd.value)) + SPAN_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      list_total <= TOTAL_W'(1);
    end else if (cfg.valid && cfg.ready) begin
      list_total <= cfg.data;
    end
  end

  // Ring: write at the tail, read at the head.
  assign ring_we = (state == ST_APPEND);
  assign ring_re = (state == ST_HEAD) || (state == ST_FRONT);

  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring[tail] <= '{value: cur_value, list_id: cur_list};
    end
    if (ring_re) begin
      ring_rd <= ring[head];
    end
  end

  // Count memory requests: reads and writes fall in distinct states.
  always_comb begin
    cnt_req         = '0;
    cnt_req.clear   = accept && elem.first;
    cnt_req.rd_addr = (state == ST_LIST) ? ring_rd.list_id : cur_list;
    cnt_req.wr_addr = (state == ST_COUNT) ? ring_rd.list_id : cur_list;
    cnt_req.rd_en   = (state == ST_LIST) || (state == ST_APPEND);
    unique case (state)
      ST_COUNT: begin
        // Evict always decrements a live count; shrink only drops duplicates.
        cnt_req.wr_en   = drop_mode ? (cnt_rd != '0) : (cnt_rd > COUNT_W'(1));
        cnt_req.wr_data = cnt_rd - 1'b1;
      end
      ST_INC: begin
        cnt_req.wr_en   = 1'b1;
        cnt_req.wr_data = cnt_rd + 1'b1;
      end
      default: begin
        cnt_req.wr_en   = 1'b0;
        cnt_req.wr_data = '0;
      end
    endcase
  end

  scrw_counts u_counts (
    .clk     (clk),
    .rst     (rst),
    .req     (cnt_req),
    .rd_data (cnt_rd)
  );

  // Item sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      drop_mode     <= 1'b0;
      head          <= '0;
      tail          <= '0;
      fill          <= '0;
      covered       <= '0;
      best_len      <= LEN_INIT;
      best_low      <= '0;
      best_high     <= '0;
      found_flag    <= 1'b0;
      overflow_flag <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            cur_value <= elem.value;
            cur_list  <= elem.list_id;
            cur_last  <= elem.last;
            // Start a new problem: drop window, coverage, best range and flags.
            if (elem.first) begin
              head          <= '0;
              tail          <= '0;
              fill          <= '0;
              covered       <= '0;
              best_len      <= LEN_INIT;
              best_low      <= '0;
              best_high     <= '0;
              found_flag    <= 1'b0;
              overflow_flag <= 1'b0;
            end
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (!list_ok) begin
            state <= ST_EMIT;
          end else if (fill == FILL_W'(WINDOW_DEPTH)) begin
            // Ring full: evict the oldest entry before appending.
            overflow_flag <= 1'b1;
            drop_mode     <= 1'b1;
            state         <= ST_HEAD;
          end else begin
            state <= ST_APPEND;
          end
        end
        ST_HEAD: begin
          state <= ST_LIST;
        end
        ST_LIST: begin
          state <= ST_COUNT;
        end
        ST_COUNT: begin
          if (drop_mode) begin
            if (cnt_rd == COUNT_W'(1) && covered != '0) begin
              covered <= covered - 1'b1;
            end
            head      <= ptr_inc(head);
            fill      <= fill - 1'b1;
            drop_mode <= 1'b0;
            state     <= ST_APPEND;
          end else if (cnt_rd > COUNT_W'(1)) begin
            // Front list still occurs later in the window: drop it.
            head  <= ptr_inc(head);
            fill  <= fill - 1'b1;
            state <= ST_SHRINK;
          end else begin
            // Front entry stays; ring_rd still holds it.
            state <= ST_SPAN;
          end
        end
        ST_APPEND: begin
          tail  <= ptr_inc(tail);
          fill  <= fill + 1'b1;
          state <= ST_INC;
        end
        ST_INC: begin
          if (cnt_rd == '0) begin
            covered <= covered + 1'b1;
          end
          state <= ST_COVER;
        end
        ST_COVER: begin
          state <= (covered == total_eff) ? ST_SHRINK : ST_EMIT;
        end
        ST_SHRINK: begin
          state <= (fill > FILL_W'(1)) ? ST_HEAD : ST_FRONT;
        end
        ST_FRONT: begin
          state <= ST_SPAN;
        end
        ST_SPAN: begin
          // Strictly smaller only, so the first of equal spans is kept.
          if (span < best_len) begin
            best_len   <= span;
            best_low   <= $signed(ring_rd.value);
            best_high  <= cur_value;
            found_flag <= 1'b1;
          end
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (emit_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Output register: hold the result until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      result.best_low   <= best_low;
      result.best_high  <= best_high;
      result.found      <= found_flag;
      result.overflowed <= overflow_flag;
      result.done_res   <= cur_last;
    end
  end

  assign result.valid = out_valid;

  `SCRW_ASSERT_ALWAYS(a_fill_bound, fill <= FILL_W'(WINDOW_DEPTH), "window fill beyond depth")
  `SCRW_ASSERT_IMPLY(a_empty_ptrs, fill == '0, head == tail, "empty window with split pointers")
  `SCRW_ASSERT_IMPLY(a_found_len, found_flag, best_len != LEN_INIT, "found without a best span")
  `SCRW_ASSERT_ALWAYS(a_cnt_port, !(cnt_req.rd_en && cnt_req.wr_en), "count read and write overlap")
  `SCRW_ASSERT_NEXT(a_emit_idle, emit_load, out_valid && state == ST_IDLE, "result not loaded")

endmodule
